// ===== design/assert_macros.svh =====
// Assertion macros shared by the interpolator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define PLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PLI_ASSERT_SAME(label, ante, cons, msg) \
  `PLI_ASSERT(label, (ante) |-> (cons), msg)

// Check that a condition implies another in the next cycle.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
  `PLI_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== design/pli_pkg.sv =====
// Types and constants of the polyline arc length interpolator.
`timescale 1ns / 1ps
package pli_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_FALLBACK = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [1:0]         lane;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
    logic signed [15:0] heading_z;
    logic signed [31:0] query_distance;
  } pli_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_dir_x;
    logic signed [15:0] out_dir_y;
    logic signed [15:0] out_dir_z;
    logic [31:0]        lane_length;
    logic [6:0]         lane_points;
    status_t            status;
  } pli_out_t;

  // One stored point: position, unit heading and cumulative arc length.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic signed [15:0] hz;
    logic [31:0]        arc;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_FULL, S_QLEN, S_QSCAN, S_QROW0, S_QDIV,
    S_LMUL, S_LADD, S_NMUL, S_NACC, S_NSQRT, S_NDIV, S_NDIVW, S_NDONE,
    S_APREV, S_AMUL, S_AACC, S_ASQRT, S_ASQW, S_AWR
  } fsm_t;

  localparam int DIV_NUM_W   = 56;
  localparam int DIV_DEN_W   = 32;
  localparam int SQRT_RAD_W  = 64;
  localparam int SQRT_ROOT_W = 32;
  localparam int MUL_W       = 34;
  localparam int FRAC_W      = 24;
  localparam logic signed [15:0] UNIT_ONE = 16'sd16384;
  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

endpackage

// ===== design/pli_mem.sv =====
// Point store: one write port, one registered read port.
`timescale 1ns / 1ps
module pli_mem #(
  parameter int DEPTH  = 192,
  parameter int ADDR_W = 8
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  pli_pkg::entry_t       wr_data,
  input  logic [ADDR_W-1:0]     rd_addr,
  output pli_pkg::entry_t       rd_data
);
  import pli_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/pli_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pli_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pli_pkg::DIV_NUM_W-1:0]  num,
  input  logic [pli_pkg::DIV_DEN_W-1:0]  den,
  output logic                           busy,
  output logic                           done,
  output logic [pli_pkg::DIV_NUM_W-1:0]  quo
);
  import pli_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] dvd;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   rem_t;
  logic                 take;
  logic [CW-1:0]        cnt;

  assign rem_t = {rem, dvd[DIV_NUM_W-1]};
  assign take  = rem_t >= {1'b0, dvs};
  assign quo   = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= num;
      dvs <= den;
      rem <= '0;
    end else if (busy) begin
      rem <= take ? DIV_DEN_W'(rem_t - {1'b0, dvs}) : DIV_DEN_W'(rem_t);
      dvd <= {dvd[DIV_NUM_W-2:0], take};
    end
  end

  `PLI_ASSERT_SAME(a_div_no_restart, start, !busy, "divider started while busy")

endmodule

// ===== design/pli_isqrt.sv =====
// Integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pli_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pli_pkg::SQRT_RAD_W-1:0]  rad,
  output logic                            busy,
  output logic                            done,
  output logic [pli_pkg::SQRT_ROOT_W-1:0] root
);
  import pli_pkg::*;

  localparam int CW  = $clog2(SQRT_ROOT_W + 1);
  localparam int REM_W = SQRT_ROOT_W + 1;

  logic [SQRT_RAD_W-1:0] src;
  logic [REM_W-1:0]      rem;
  logic [REM_W+1:0]      rem_t;
  logic [REM_W+1:0]      trial;
  logic                  take;
  logic [CW-1:0]         cnt;

  assign rem_t = {rem, src[SQRT_RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign take  = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SQRT_ROOT_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src  <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src  <= {src[SQRT_RAD_W-3:0], 2'b00};
      rem  <= take ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root <= {root[SQRT_ROOT_W-2:0], take};
    end
  end

  `PLI_ASSERT_SAME(a_sqrt_no_restart, start, !busy, "square root started while busy")

endmodule

// ===== design/polyline_arc_length_interpolator.sv =====
// Top level: lane polylines in a point store, append, query and clear sequencer.
//
//   channel   direction  handshake          word
//   command   in         start / busy       cmd (pli_in_t)
//   result    out        done, one cycle    result (pli_out_t)
//   config    in         cfg_we             cfg_wdata (lane spacing)
//
// Paths: clear, unused kinds, full or unknown lanes and empty-lane queries
// finish without the divider or square-root unit. Appends and queries may
// use both, and a query first scans the lane's points one by one. Divisions:
// three per heading normalize, one more per query.
// Reset: synchronous, clears lane counts and sets lane spacing to 200; the
// point store needs no clearing, only entries below a lane's count are read.
// Stalls: none; busy is high while a command is in flight and done is high
// for exactly one cycle per command.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module polyline_arc_length_interpolator #(
  parameter int MAX_POINTS = 64,
  parameter int NUM_LANES  = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pli_pkg::pli_in_t  cmd,
  output logic              done,
  output pli_pkg::pli_out_t result,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  import pli_pkg::*;

  localparam int DEPTH   = NUM_LANES * MAX_POINTS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int LANE_IW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

  // Held command and control state.
  fsm_t              state, state_next;
  pli_in_t           cq;
  logic [CNT_W-1:0]  cnt [NUM_LANES];
  logic [15:0]       spacing;

  // Datapath registers.
  entry_t             row0, row1;
  logic [31:0]        qdist, qlen, total;
  logic               sat;
  logic [IDX_W-1:0]   j;
  logic [2:0]         k;
  logic [65:0]        acc;
  logic signed [67:0] prod;
  logic [FRAC_W:0]    afrac;
  logic signed [31:0] res_pos [3];
  logic signed [15:0] nvec [3];
  logic signed [15:0] nout [3];

  // Lane decode.
  logic [2:0]         lane_ext;
  logic               lane_ok;
  logic [LANE_IW-1:0] lane_idx;
  logic [CNT_W-1:0]   n;
  logic [ADDR_W-1:0]  base;

  assign lane_ext = {1'b0, cq.lane};
  assign lane_ok  = 4'(cq.lane) < 4'(NUM_LANES);
  assign lane_idx = lane_ext[LANE_IW-1:0];
  assign n        = lane_ok ? cnt[lane_idx] : '0;
  assign base     = ADDR_W'(lane_idx) * ADDR_W'(MAX_POINTS);

  // Store, divider and square-root hookup.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_data, rd_data;
  logic              div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic              sq_start, sq_busy, sq_done;
  logic [SQRT_RAD_W-1:0]  sq_rad;
  logic [SQRT_ROOT_W-1:0] sq_root;

  pli_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  pli_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  pli_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .rad(sq_rad),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  // Component k of a point: positions first, then headings.
  function automatic logic signed [31:0] comp_of(entry_t e, logic [2:0] idx);
    logic signed [31:0] v;
    case (idx)
      3'd0:    v = e.x;
      3'd1:    v = e.y;
      3'd2:    v = e.z;
      3'd3:    v = 32'(e.hx);
      3'd4:    v = 32'(e.hy);
      3'd5:    v = 32'(e.hz);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] cmd_pos(pli_in_t c, logic [2:0] idx);
    logic signed [31:0] v;
    case (idx)
      3'd0:    v = c.point_x;
      3'd1:    v = c.point_y;
      default: v = c.point_z;
    endcase
    return v;
  endfunction

  // Multiplier operands and helpers.
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [32:0]      ldiff, adiff;
  logic [32:0]             amag;
  logic [67:0]             pmag, prnd;
  logic [31:0]             q32;
  logic signed [31:0]      lval;
  logic [2:0]              kh;
  logic signed [15:0]      nk;
  logic [16:0]             nmag;
  logic signed [15:0]      qclamp;
  logic [31:0]             dclamp;
  logic [32:0]             arc_sum;
  logic [65:0]             acc_sum;
  logic [31:0]             sp32;
  logic signed [31:0]      fb_y;

  assign ldiff   = 33'(comp_of(row1, k)) - 33'(comp_of(row0, k));
  assign adiff   = 33'(cmd_pos(cq, k)) - 33'(comp_of(row0, k));
  assign amag    = adiff[32] ? 33'(-adiff) : 33'(adiff);
  assign pmag    = prod[67] ? $unsigned(-prod) : $unsigned(prod);
  assign prnd    = pmag + 68'(1 << (FRAC_W - 1));
  assign q32     = prnd[FRAC_W +: 32];
  assign lval    = comp_of(row0, k) + (prod[67] ? -$signed(q32) : $signed(q32));
  assign kh      = k - 3'd3;
  assign nk      = nvec[k[1:0]];
  assign nmag    = nk[15] ? 17'(-(17'(nk))) : 17'(nk);
  assign qclamp  = (div_quo > DIV_NUM_W'(UNIT_ONE)) ? UNIT_ONE : 16'(div_quo);
  assign arc_sum = {1'b0, row0.arc} + {1'b0, sq_root};
  assign acc_sum = acc + 66'(prod);
  assign sp32    = {8'd0, spacing, 8'd0};

  // Clamp the query distance to [0, lane length].
  always_comb begin
    if (cq.query_distance[31]) begin
      dclamp = '0;
    end else if (32'(cq.query_distance) > rd_data.arc) begin
      dclamp = rd_data.arc;
    end else begin
      dclamp = 32'(cq.query_distance);
    end
  end

  // Lateral offset of an empty lane: (lane - 1) * spacing * 256.
  always_comb begin
    case (cq.lane)
      2'd0:    fb_y = -$signed(sp32);
      2'd1:    fb_y = '0;
      2'd2:    fb_y = $signed(sp32);
      default: fb_y = $signed({sp32[30:0], 1'b0});
    endcase
  end

  // Next state, store and unit controls, result word.
  logic     emit;
  pli_out_t res_next;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    res_next   = '0;
    rd_addr    = base;
    wr_en      = 1'b0;
    wr_addr    = base + ADDR_W'(n);
    wr_data    = '{x: cq.point_x, y: cq.point_y, z: cq.point_z,
                   hx: nout[0], hy: nout[1], hz: nout[2], arc: total};
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sq_start   = 1'b0;
    sq_rad     = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cq.kind)
          KIND_APPEND: begin
            if (!lane_ok) begin
              emit            = 1'b1;
              res_next.status = ST_FULL;
              state_next      = S_IDLE;
            end else if (n == CNT_W'(MAX_POINTS)) begin
              rd_addr    = base + ADDR_W'(n - CNT_W'(1));
              state_next = S_FULL;
            end else begin
              state_next = S_NMUL;
            end
          end
          KIND_QUERY: begin
            if (n == '0) begin
              emit                 = 1'b1;
              res_next.out_x       = cq.query_distance;
              res_next.out_y       = fb_y;
              res_next.out_dir_x   = UNIT_ONE;
              res_next.status      = ST_FALLBACK;
              state_next           = S_IDLE;
            end else begin
              rd_addr    = base + ADDR_W'(n - CNT_W'(1));
              state_next = S_QLEN;
            end
          end
          default: begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_FULL: begin
        emit                 = 1'b1;
        res_next.lane_length = rd_data.arc;
        res_next.lane_points = 7'(n);
        res_next.status      = ST_FULL;
        state_next           = S_IDLE;
      end
      S_QLEN: begin
        if (n == CNT_W'(1)) begin
          emit                 = 1'b1;
          res_next.out_x       = rd_data.x;
          res_next.out_y       = rd_data.y;
          res_next.out_z       = rd_data.z;
          res_next.out_dir_x   = rd_data.hx;
          res_next.out_dir_y   = rd_data.hy;
          res_next.out_dir_z   = rd_data.hz;
          res_next.lane_length = rd_data.arc;
          res_next.lane_points = 7'(n);
          state_next           = S_IDLE;
        end else begin
          rd_addr    = base + ADDR_W'(1);
          state_next = S_QSCAN;
        end
      end
      S_QSCAN: begin
        if (rd_data.arc >= qdist || j == IDX_W'(n - CNT_W'(1))) begin
          rd_addr    = base + ADDR_W'(j - IDX_W'(1));
          state_next = S_QROW0;
        end else begin
          rd_addr    = base + ADDR_W'(j + IDX_W'(1));
          state_next = S_QSCAN;
        end
      end
      S_QROW0: begin
        if (row1.arc == rd_data.arc) begin
          emit                 = 1'b1;
          res_next.out_x       = rd_data.x;
          res_next.out_y       = rd_data.y;
          res_next.out_z       = rd_data.z;
          res_next.out_dir_x   = rd_data.hx;
          res_next.out_dir_y   = rd_data.hy;
          res_next.out_dir_z   = rd_data.hz;
          res_next.lane_length = qlen;
          res_next.lane_points = 7'(n);
          state_next           = S_IDLE;
        end else begin
          div_start  = 1'b1;
          div_num    = {qdist - rd_data.arc, FRAC_W'(0)};
          div_den    = row1.arc - rd_data.arc;
          state_next = S_QDIV;
        end
      end
      S_QDIV: begin
        if (div_done) begin
          state_next = S_LMUL;
        end
      end
      S_LMUL: begin
        mul_a      = MUL_W'(ldiff);
        mul_b      = $signed(MUL_W'(afrac));
        state_next = S_LADD;
      end
      S_LADD: begin
        state_next = (k == 3'd5) ? S_NMUL : S_LMUL;
      end
      S_NMUL: begin
        mul_a      = MUL_W'(nk);
        mul_b      = MUL_W'(nk);
        state_next = S_NACC;
      end
      S_NACC: begin
        if (k != 3'd2) begin
          state_next = S_NMUL;
        end else if (acc_sum == '0) begin
          state_next = S_NDONE;
        end else begin
          sq_start   = 1'b1;
          sq_rad     = SQRT_RAD_W'(acc_sum[47:0]) << 16;
          state_next = S_NSQRT;
        end
      end
      S_NSQRT: begin
        if (sq_done) begin
          state_next = S_NDIV;
        end
      end
      S_NDIV: begin
        div_start  = 1'b1;
        div_num    = DIV_NUM_W'({nmag, 22'd0}) + DIV_NUM_W'(sq_root >> 1);
        div_den    = sq_root;
        state_next = S_NDIVW;
      end
      S_NDIVW: begin
        if (div_done) begin
          state_next = (k == 3'd2) ? S_NDONE : S_NDIV;
        end
      end
      S_NDONE: begin
        if (cq.kind == KIND_APPEND) begin
          if (n == '0) begin
            state_next = S_AWR;
          end else begin
            rd_addr    = base + ADDR_W'(n - CNT_W'(1));
            state_next = S_APREV;
          end
        end else begin
          emit                 = 1'b1;
          res_next.out_x       = res_pos[0];
          res_next.out_y       = res_pos[1];
          res_next.out_z       = res_pos[2];
          res_next.out_dir_x   = nout[0];
          res_next.out_dir_y   = nout[1];
          res_next.out_dir_z   = nout[2];
          res_next.lane_length = qlen;
          res_next.lane_points = 7'(n);
          state_next           = S_IDLE;
        end
      end
      S_APREV: begin
        state_next = S_AMUL;
      end
      S_AMUL: begin
        mul_a      = $signed({1'b0, amag});
        mul_b      = $signed({1'b0, amag});
        state_next = S_AACC;
      end
      S_AACC: begin
        state_next = (k == 3'd2) ? S_ASQRT : S_AMUL;
      end
      S_ASQRT: begin
        if (acc[65:64] != 2'b00) begin
          state_next = S_AWR;
        end else begin
          sq_start   = 1'b1;
          sq_rad     = acc[63:0];
          state_next = S_ASQW;
        end
      end
      S_ASQW: begin
        if (sq_done) begin
          state_next = S_AWR;
        end
      end
      S_AWR: begin
        wr_en                = 1'b1;
        emit                 = 1'b1;
        res_next.lane_length = total;
        res_next.lane_points = 7'(n + CNT_W'(1));
        res_next.status      = sat ? ST_SAT : ST_OK;
        state_next           = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // Control registers: state, strobe, lane counts, spacing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      spacing <= 16'd200;
      for (int i = 0; i < NUM_LANES; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= emit;
      if (cfg_we) begin
        spacing <= cfg_wdata;
      end
      if (state == S_DECODE && cq.kind == KIND_CLEAR) begin
        for (int i = 0; i < NUM_LANES; i++) begin
          cnt[i] <= '0;
        end
      end
      if (state == S_AWR) begin
        cnt[lane_idx] <= n + CNT_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= 68'(mul_a) * 68'(mul_b);
    if (emit) begin
      result <= res_next;
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          cq <= cmd;
        end
      end
      S_DECODE: begin
        // Prepare a heading normalize for an append.
        nvec[0] <= cq.heading_x;
        nvec[1] <= cq.heading_y;
        nvec[2] <= cq.heading_z;
        k       <= '0;
        acc     <= '0;
        total   <= '0;
        sat     <= 1'b0;
      end
      S_QLEN: begin
        qlen  <= rd_data.arc;
        qdist <= dclamp;
        j     <= IDX_W'(1);
      end
      S_QSCAN: begin
        row1 <= rd_data;
        j    <= j + IDX_W'(1);
      end
      S_QROW0: begin
        row0 <= rd_data;
      end
      S_QDIV: begin
        afrac <= div_quo[FRAC_W:0];
        k     <= '0;
      end
      S_LADD: begin
        if (k < 3'd3) begin
          res_pos[k[1:0]] <= lval;
        end else begin
          nvec[kh[1:0]] <= 16'(lval);
        end
        if (k == 3'd5) begin
          k   <= '0;
          acc <= '0;
        end else begin
          k <= k + 3'd1;
        end
      end
      S_NACC: begin
        acc <= acc_sum;
        if (k != 3'd2) begin
          k <= k + 3'd1;
        end else begin
          k <= '0;
          if (acc_sum == '0) begin
            nout[0] <= '0;
            nout[1] <= '0;
            nout[2] <= '0;
          end
        end
      end
      S_NDIVW: begin
        if (div_done) begin
          nout[k[1:0]] <= nk[15] ? -qclamp : qclamp;
          k <= k + 3'd1;
        end
      end
      S_APREV: begin
        row0 <= rd_data;
        k    <= '0;
        acc  <= '0;
      end
      S_AACC: begin
        acc <= acc_sum;
        k   <= k + 3'd1;
      end
      S_ASQRT: begin
        if (acc[65:64] != 2'b00) begin
          total <= LEN_MAX;
          sat   <= 1'b1;
        end
      end
      S_ASQW: begin
        if (sq_done) begin
          total <= arc_sum[32] ? LEN_MAX : arc_sum[31:0];
          sat   <= arc_sum[32];
        end
      end
      default: begin
      end
    endcase
  end

  // A result strobe always ends a command and lasts one cycle.
  `PLI_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without a command")
  `PLI_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  // Points are only written into a known lane that still has room.
  `PLI_ASSERT_SAME(a_write_in_lane, wr_en, lane_ok && (n < CNT_W'(MAX_POINTS)), "bad point write")

endmodule
